[rtl/psnm_pkg.sv]
// psnm_pkg: shared types and constants of the point set near match block
// item and point structs, item kind codes, field widths and reset values
// depends on nothing
package psnm_pkg;

  localparam int unsigned CoordBits        = 24;
  localparam int unsigned TolBits          = 23;
  localparam int unsigned MaxPointsDefault = 1024;
  localparam logic [TolBits-1:0] TolReset  = TolBits'(80);

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]                  kind;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic near;
    logic overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } point_t;

  localparam int unsigned PointBits = $bits(point_t);

endpackage

[rtl/psnm_mem.sv]
// psnm_mem: single-port synchronous point table with a registered read port
// depends on psnm_pkg for the point type
module psnm_mem #(
  parameter int unsigned DEPTH  = psnm_pkg::MaxPointsDefault,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  addr_i,
  input  psnm_pkg::point_t   wdata_i,
  output psnm_pkg::point_t   rdata_o
);

  psnm_pkg::point_t mem_q [DEPTH];
  psnm_pkg::point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/psnm_match.sv]
// psnm_match: chebyshev box test of one stored point against the query point
// depends on psnm_pkg for the point type and widths
module psnm_match (
  input  psnm_pkg::point_t                  entry_i,
  input  psnm_pkg::point_t                  query_i,
  input  logic [psnm_pkg::TolBits-1:0]      tol_i,
  output logic                              match_o
);

  localparam int unsigned DiffW = psnm_pkg::CoordBits + 1;

  logic signed [DiffW-1:0] diff_x, diff_y;
  logic        [DiffW-1:0] abs_x, abs_y;
  logic        [DiffW-1:0] tol_ext;

  // exact differences, one bit wider than the coordinates
  assign diff_x = DiffW'(entry_i.x) - DiffW'(query_i.x);
  assign diff_y = DiffW'(entry_i.y) - DiffW'(query_i.y);
  assign abs_x  = diff_x[DiffW-1] ? DiffW'(-diff_x) : DiffW'(diff_x);
  assign abs_y  = diff_y[DiffW-1] ? DiffW'(-diff_y) : DiffW'(diff_y);
  assign tol_ext = {{(DiffW - psnm_pkg::TolBits){1'b0}}, tol_i};

  assign match_o = (abs_x <= tol_ext) && (abs_y <= tol_ext);

endmodule

[rtl/point_set_near_match.sv]
// point_set_near_match: clear and load never stall the input and yield no transaction.
// a query holds in_stall_o while it scans the loaded entries (one table read per cycle
// through the single memory port), and longer while out_stall_i holds the previous result;
// it stops early on a match. reset clears point count, overflow flag and output valid,
// tolerance returns to 80; table contents stay undefined and need no clearing pass.
module point_set_near_match #(
  parameter int unsigned MAX_POINTS = psnm_pkg::MaxPointsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  psnm_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output psnm_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [psnm_pkg::TolBits-1:0]  cfg_data_i
);

  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_POINTS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                          state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  logic                          ovf_q, ovf_d;
  logic [CntW-1:0]               issue_q, issue_d;
  logic                          pend_q, pend_d;
  logic                          hit_q, hit_d;
  logic [psnm_pkg::TolBits-1:0]  tol_q;
  psnm_pkg::point_t              qry_q, qry_d;
  logic                          out_valid_q, out_valid_d;
  psnm_pkg::out_item_t           out_data_q, out_data_d;

  logic                          in_acc;
  logic                          out_free;
  logic                          scan_done;
  logic                          mem_en, mem_we;
  logic [AddrW-1:0]              mem_addr;
  psnm_pkg::point_t              mem_wdata, mem_rdata;
  logic                          match;

  psnm_mem #(
    .DEPTH  (MAX_POINTS),
    .ADDR_W (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  psnm_match u_match (
    .entry_i (mem_rdata),
    .query_i (qry_q),
    .tol_i   (tol_q),
    .match_o (match)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign scan_done   = !pend_q && (hit_q || (issue_q == count_q));
  assign cfg_ready_o = 1'b1;
  assign mem_wdata   = '{x: in_data_i.pos_x, y: in_data_i.pos_y};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    hit_d       = hit_q;
    qry_d       = qry_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = count_q[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.kind)
            psnm_pkg::KIND_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            psnm_pkg::KIND_LOAD: begin
              if (count_q < MaxCnt) begin
                mem_en  = 1'b1;
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            psnm_pkg::KIND_QUERY: begin
              qry_d   = '{x: in_data_i.pos_x, y: in_data_i.pos_y};
              issue_d = '0;
              hit_d   = 1'b0;
              state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // one read per cycle; stop issuing once a match is seen
        if (!hit_q && (issue_q != count_q)) begin
          mem_en   = 1'b1;
          mem_addr = issue_q[AddrW-1:0];
          issue_d  = issue_q + 1'b1;
          pend_d   = 1'b1;
        end
        if (pend_q && match) begin
          hit_d = 1'b1;
        end
        if (scan_done && out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{near: hit_q, overflow: ovf_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      tol_q       <= psnm_pkg::TolReset;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q      <= qry_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("point count beyond table depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == MaxCnt))
    else $error("overflow set while table not full");

  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_SCAN))
    else $error("result produced outside a query scan");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_en && !mem_we) |-> ((state_q == S_SCAN) && (issue_q < count_q)))
    else $error("table read beyond loaded entries");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !mem_we)
    else $error("table written during a query scan");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for point_set_near_match, with an in-bench box-distance predictor
// depends on psnm_pkg (item structs, kind codes, widths) and the point_set_near_match rtl
module testbench;

  localparam int HalfPeriod = 6;
  localparam int unsigned TableDepth = psnm_pkg::MaxPointsDefault;
  localparam int ItemTarget = 580;
  localparam int SettleCycles = 8;
  localparam int unsigned CycleLimit = 400000;
  localparam int MaxCoord = 8388607;
  localparam int MinCoord = -8388608;
  localparam int TolMax = (1 << psnm_pkg::TolBits) - 1;
  localparam logic [1:0] KindUnused = 2'd3;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_e;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  psnm_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  psnm_pkg::out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [psnm_pkg::TolBits-1:0] cfg_data_i = '0;

  // predictor state
  psnm_pkg::point_t known_points [TableDepth];
  int unsigned known_count = 0;
  logic drop_seen = 1'b0;
  logic [psnm_pkg::TolBits-1:0] match_tol = psnm_pkg::TolReset;

  psnm_pkg::in_item_t point_items [$];
  psnm_pkg::out_item_t expected_matches [$];
  int queued_items = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int unsigned cycle_count = 0;

  bit item_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int stall_phase_left = 0;
  int stall_run = 0;
  bit stall_level = 1'b0;

  point_set_near_match #(
    .MAX_POINTS(TableDepth)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  always #HalfPeriod clk = ~clk;

  // chebyshev box test with exact 25-bit differences
  function automatic logic within_box(psnm_pkg::point_t a, psnm_pkg::point_t b,
                                      logic [psnm_pkg::TolBits-1:0] tol);
    logic signed [psnm_pkg::CoordBits:0] dx, dy;
    logic [psnm_pkg::CoordBits:0] ax, ay;
    dx = {a.x[psnm_pkg::CoordBits-1], a.x} - {b.x[psnm_pkg::CoordBits-1], b.x};
    dy = {a.y[psnm_pkg::CoordBits-1], a.y} - {b.y[psnm_pkg::CoordBits-1], b.y};
    ax = dx[psnm_pkg::CoordBits] ? -dx : dx;
    ay = dy[psnm_pkg::CoordBits] ? -dy : dy;
    return (ax <= {2'b00, tol}) && (ay <= {2'b00, tol});
  endfunction

  task automatic apply_to_point_set(input psnm_pkg::in_item_t item);
    psnm_pkg::point_t probe;
    psnm_pkg::out_item_t res;
    logic hit;
    case (item.kind)
      psnm_pkg::KIND_CLEAR: begin
        known_count = 0;
        drop_seen = 1'b0;
      end
      psnm_pkg::KIND_LOAD: begin
        if (known_count < TableDepth) begin
          known_points[known_count].x = item.pos_x;
          known_points[known_count].y = item.pos_y;
          known_count++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      psnm_pkg::KIND_QUERY: begin
        probe.x = item.pos_x;
        probe.y = item.pos_y;
        hit = 1'b0;
        for (int i = 0; i < int'(known_count) && !hit; i++) begin
          hit = within_box(known_points[i], probe, match_tol);
        end
        res.near = hit;
        res.overflow = drop_seen;
        expected_matches = {expected_matches, res};
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatch_count++;
  endtask

  task automatic compare_result(input psnm_pkg::out_item_t got);
    psnm_pkg::out_item_t want;
    if (expected_matches.size() == 0) begin
      report_mismatch($sformatf("unexpected result near=%0b overflow=%0b",
                                got.near, got.overflow));
    end else begin
      want = expected_matches.pop_front();
      if (got.near !== want.near)
        report_mismatch($sformatf("near got %0b want %0b", got.near, want.near));
      if (got.overflow !== want.overflow)
        report_mismatch($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
    end
    results_seen++;
  endtask

  // monitor: input acceptance feeds the predictor, output acceptance is checked
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_to_point_set(in_data_i);
        item_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) compare_result(out_data_o);
    end
  end

  // driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (!in_valid_i || item_taken) begin
      item_taken = 1'b0;
      if (gap_left != 0 || point_items.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= point_items.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver stall pattern: open, one-in-three random stall, or runs of stall and open
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_phase_left = $urandom_range(50, 300);
    end else begin
      stall_phase_left--;
    end
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_run == 0) begin
          stall_level = ~stall_level;
          stall_run = $urandom_range(1, 12);
        end else begin
          stall_run--;
        end
        out_stall_i <= stall_level;
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("point_set_near_match test failed");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] k, input int x, input int y);
    psnm_pkg::in_item_t it;
    it.kind = k;
    it.pos_x = x[psnm_pkg::CoordBits-1:0];
    it.pos_y = y[psnm_pkg::CoordBits-1:0];
    point_items = {point_items, it};
    if (k != KindUnused) queued_items++;
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return MaxCoord;
      1: return MinCoord;
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic int edge_offset(input int t);
    case ($urandom_range(0, 4))
      0: return t;
      1: return -t;
      2: return t + 1;
      3: return -t - 1;
      default: return 0;
    endcase
  endfunction

  // block is idle once every transaction is in, every result is out and a load had time to land
  // checked at the rising edge, where the driver's last change has settled
  task automatic wait_idle();
    while (point_items.size() != 0 || in_valid_i || expected_matches.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_tolerance(input int t);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= t[psnm_pkg::TolBits-1:0];
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    match_tol = t[psnm_pkg::TolBits-1:0];
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int t, n, m, spread, cx, cy, j, r, random_start, ox, oy;
    int stim_x [$];
    int stim_y [$];

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // directed: reset tolerance, empty table, extremes, ignored kind, clear
    push_item(psnm_pkg::KIND_QUERY, 0, 0);
    push_item(KindUnused, rand_coord(), rand_coord());
    push_item(psnm_pkg::KIND_LOAD, MaxCoord, MaxCoord);
    push_item(psnm_pkg::KIND_LOAD, MinCoord, MinCoord);
    push_item(psnm_pkg::KIND_LOAD, 0, 0);
    push_item(psnm_pkg::KIND_QUERY, MinCoord, MaxCoord);
    push_item(psnm_pkg::KIND_QUERY, MaxCoord - 80, MaxCoord);
    push_item(psnm_pkg::KIND_QUERY, MaxCoord - 81, MaxCoord);
    push_item(psnm_pkg::KIND_QUERY, MinCoord + 80, MinCoord + 80);
    push_item(psnm_pkg::KIND_QUERY, 80, -81);
    push_item(psnm_pkg::KIND_QUERY, -80, 80);
    push_item(KindUnused, 0, 0);
    push_item(psnm_pkg::KIND_CLEAR, 0, 0);
    push_item(psnm_pkg::KIND_QUERY, 0, 0);
    push_item(psnm_pkg::KIND_LOAD, 5, 5);
    push_item(psnm_pkg::KIND_QUERY, 5, 5);
    wait_idle();
    write_tolerance(TolMax);
    push_item(psnm_pkg::KIND_CLEAR, 0, 0);
    push_item(psnm_pkg::KIND_LOAD, MaxCoord, MaxCoord);
    push_item(psnm_pkg::KIND_QUERY, 0, 0);
    push_item(psnm_pkg::KIND_QUERY, -1, 0);
    push_item(psnm_pkg::KIND_QUERY, MinCoord, MinCoord);
    wait_idle();
    write_tolerance(0);
    push_item(psnm_pkg::KIND_QUERY, MaxCoord, MaxCoord);
    push_item(psnm_pkg::KIND_QUERY, MaxCoord, MaxCoord - 1);

    // random phases: new tolerance, a clustered table, then mostly near queries
    random_start = queued_items;
    while (queued_items - random_start < ItemTarget) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0: t = 0;
        1: t = 1;
        2: t = TolMax;
        3: t = 80;
        4, 5: t = $urandom_range(2, 300);
        6: t = $urandom_range(300, 70000);
        default: t = $urandom_range(0, TolMax);
      endcase
      write_tolerance(t);
      if (stim_x.size() > 100 || $urandom_range(0, 5) != 0) begin
        push_item(psnm_pkg::KIND_CLEAR, rand_coord(), rand_coord());
        stim_x.delete();
        stim_y.delete();
      end
      cx = rand_coord();
      cy = rand_coord();
      spread = $urandom_range(1, 4 * t + 50);
      n = $urandom_range(0, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          stim_x = {stim_x, rand_coord()};
          stim_y = {stim_y, rand_coord()};
        end else begin
          stim_x = {stim_x, int'(cx + $urandom_range(0, 2 * spread) - spread)};
          stim_y = {stim_y, int'(cy + $urandom_range(0, 2 * spread) - spread)};
        end
        push_item(psnm_pkg::KIND_LOAD, stim_x[$], stim_y[$]);
      end
      m = $urandom_range(3, 12);
      for (int i = 0; i < m; i++) begin
        r = $urandom_range(0, 19);
        j = (stim_x.size() != 0) ? $urandom_range(0, stim_x.size() - 1) : 0;
        if (r == 0) begin
          push_item(KindUnused, rand_coord(), rand_coord());
        end else if (r == 1) begin
          stim_x = {stim_x, int'(cx + $urandom_range(0, 2 * spread) - spread)};
          stim_y = {stim_y, int'(cy + $urandom_range(0, 2 * spread) - spread)};
          push_item(psnm_pkg::KIND_LOAD, stim_x[$], stim_y[$]);
        end else if (r == 2) begin
          push_item(psnm_pkg::KIND_CLEAR, rand_coord(), rand_coord());
          stim_x.delete();
          stim_y.delete();
        end else if (r <= 10 && stim_x.size() != 0) begin
          ox = $urandom_range(0, 2 * t + 4) - (t + 2);
          oy = $urandom_range(0, 2 * t + 4) - (t + 2);
          push_item(psnm_pkg::KIND_QUERY, stim_x[j] + ox, stim_y[j] + oy);
        end else if (r <= 15 && stim_x.size() != 0) begin
          push_item(psnm_pkg::KIND_QUERY, stim_x[j] + edge_offset(t),
                    stim_y[j] + edge_offset(t));
        end else begin
          push_item(psnm_pkg::KIND_QUERY, rand_coord(), rand_coord());
        end
      end
    end

    // full table: exactly at capacity, then dropped loads and the sticky flag
    wait_idle();
    t = $urandom_range(0, 100);
    write_tolerance(t);
    push_item(psnm_pkg::KIND_CLEAR, 0, 0);
    stim_x.delete();
    stim_y.delete();
    for (int i = 0; i < int'(TableDepth); i++) begin
      stim_x = {stim_x, int'($urandom)};
      stim_y = {stim_y, int'($urandom)};
      push_item(psnm_pkg::KIND_LOAD, stim_x[i], stim_y[i]);
    end
    push_item(psnm_pkg::KIND_QUERY, stim_x[TableDepth - 1], stim_y[TableDepth - 1]);
    push_item(psnm_pkg::KIND_QUERY, rand_coord(), rand_coord());
    for (int i = 0; i < 3; i++) push_item(psnm_pkg::KIND_LOAD, rand_coord(), rand_coord());
    push_item(psnm_pkg::KIND_QUERY, stim_x[0], stim_y[0]);
    push_item(psnm_pkg::KIND_QUERY, stim_x[TableDepth - 1] + t, stim_y[TableDepth - 1] - t);
    push_item(psnm_pkg::KIND_QUERY, rand_coord(), rand_coord());
    push_item(KindUnused, rand_coord(), rand_coord());
    push_item(psnm_pkg::KIND_LOAD, 0, 0);
    push_item(psnm_pkg::KIND_QUERY, stim_x[TableDepth / 2] + t + 1, stim_y[TableDepth / 2]);
    push_item(psnm_pkg::KIND_CLEAR, 0, 0);
    push_item(psnm_pkg::KIND_QUERY, stim_x[0], stim_y[0]);
    push_item(psnm_pkg::KIND_LOAD, stim_x[0], stim_y[0]);
    push_item(psnm_pkg::KIND_QUERY, stim_x[0], stim_y[0]);

    wait_idle();
    repeat (TableDepth + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_matches.size() == 0) begin
      $display("point_set_near_match test passed");
    end else begin
      $display("point_set_near_match test failed");
    end
    $finish;
  end

endmodule

[point_set_near_match.f]
rtl/psnm_pkg.sv
rtl/psnm_mem.sv
rtl/psnm_match.sv
rtl/point_set_near_match.sv
sim/testbench.sv
